>>> rtl/egcd_pkg.sv
// Package for the extended gcd block: widths, microcode encodings and the
// structs passed between the sequencer and the datapath. No dependencies.
package egcd_pkg;

   localparam int OPERAND_WIDTH = 32;
   localparam int COEFF_WIDTH   = OPERAND_WIDTH + 1;
   localparam int COUNT_WIDTH   = $clog2(OPERAND_WIDTH);
   localparam int STEP_WIDTH    = 3;
   localparam int OP_WIDTH      = 3;
   localparam int COND_WIDTH    = 3;

   // Datapath operations.
   localparam logic [OP_WIDTH-1:0] OP_NOP      = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_LOAD     = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_DIV_INIT = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_DIV_STEP = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_UPDATE   = 3'd4;
   localparam logic [OP_WIDTH-1:0] OP_EMIT     = 3'd5;

   // Jump conditions.
   localparam logic [COND_WIDTH-1:0] COND_NEVER    = 3'd0;
   localparam logic [COND_WIDTH-1:0] COND_ALWAYS   = 3'd1;
   localparam logic [COND_WIDTH-1:0] COND_NO_REQ   = 3'd2;
   localparam logic [COND_WIDTH-1:0] COND_CUR_ZERO = 3'd3;
   localparam logic [COND_WIDTH-1:0] COND_COUNT_NZ = 3'd4;
   localparam logic [COND_WIDTH-1:0] COND_OUT_BUSY = 3'd5;

   // Microprogram addresses.
   localparam logic [STEP_WIDTH-1:0] STEP_IDLE     = 3'd0;
   localparam logic [STEP_WIDTH-1:0] STEP_TEST     = 3'd1;
   localparam logic [STEP_WIDTH-1:0] STEP_DIV_INIT = 3'd2;
   localparam logic [STEP_WIDTH-1:0] STEP_DIV_STEP = 3'd3;
   localparam logic [STEP_WIDTH-1:0] STEP_UPDATE   = 3'd4;
   localparam logic [STEP_WIDTH-1:0] STEP_EMIT     = 3'd5;

   typedef struct packed {
      logic [OP_WIDTH-1:0]   op;
      logic [COND_WIDTH-1:0] cond;
      logic [STEP_WIDTH-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic cur_zero;
      logic count_nz;
      logic out_busy;
   } status_type;

endpackage

>>> rtl/egcd_if.sv
// Valid/ready channel interfaces for the request and the result.
// Depends on egcd_pkg for the payload widths.
interface egcd_req_if;
   logic                                valid;
   logic                                ready;
   logic [egcd_pkg::OPERAND_WIDTH-1:0] operand_a;
   logic [egcd_pkg::OPERAND_WIDTH-1:0] operand_b;

   modport source (output valid, output operand_a, output operand_b, input ready);
   modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface egcd_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic        [egcd_pkg::OPERAND_WIDTH-1:0] divisor;
   logic signed [egcd_pkg::COEFF_WIDTH-1:0]   coeff_a;
   logic signed [egcd_pkg::COEFF_WIDTH-1:0]   coeff_b;

   modport source (output valid, output divisor, output coeff_a, output coeff_b,
                   input ready);
   modport sink   (input valid, input divisor, input coeff_a, input coeff_b,
                   output ready);
endinterface

>>> rtl/egcd_ucode_rom.sv
// Microcode read-only table: one control word per program step.
// Depends on egcd_pkg.
module egcd_ucode_rom (
   input  logic [egcd_pkg::STEP_WIDTH-1:0] step,
   output egcd_pkg::ctrl_word_type         ctrl
);

   always_comb begin
      unique case (step)
         egcd_pkg::STEP_IDLE:
            ctrl = '{egcd_pkg::OP_LOAD, egcd_pkg::COND_NO_REQ, egcd_pkg::STEP_IDLE};
         egcd_pkg::STEP_TEST:
            ctrl = '{egcd_pkg::OP_NOP, egcd_pkg::COND_CUR_ZERO, egcd_pkg::STEP_EMIT};
         egcd_pkg::STEP_DIV_INIT:
            ctrl = '{egcd_pkg::OP_DIV_INIT, egcd_pkg::COND_NEVER, egcd_pkg::STEP_IDLE};
         egcd_pkg::STEP_DIV_STEP:
            ctrl = '{egcd_pkg::OP_DIV_STEP, egcd_pkg::COND_COUNT_NZ,
                     egcd_pkg::STEP_DIV_STEP};
         egcd_pkg::STEP_UPDATE:
            ctrl = '{egcd_pkg::OP_UPDATE, egcd_pkg::COND_ALWAYS, egcd_pkg::STEP_TEST};
         egcd_pkg::STEP_EMIT:
            ctrl = '{egcd_pkg::OP_EMIT, egcd_pkg::COND_OUT_BUSY, egcd_pkg::STEP_EMIT};
         default:
            ctrl = '{egcd_pkg::OP_NOP, egcd_pkg::COND_ALWAYS, egcd_pkg::STEP_IDLE};
      endcase
   end

endmodule

>>> rtl/egcd_sequencer.sv
// Step counter with conditional jumps; fetches control words from the table.
// Depends on egcd_pkg and egcd_ucode_rom.
module egcd_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  egcd_pkg::status_type    status,
   output egcd_pkg::ctrl_word_type ctrl,
   output logic                    idle
);

   logic [egcd_pkg::STEP_WIDTH-1:0] step_ff;
   logic [egcd_pkg::STEP_WIDTH-1:0] step_in;
   logic                            jump;

   egcd_ucode_rom u_rom (
      .step (step_ff),
      .ctrl (ctrl)
   );

   always_comb begin
      unique case (ctrl.cond)
         egcd_pkg::COND_NEVER:    jump = 1'b0;
         egcd_pkg::COND_ALWAYS:   jump = 1'b1;
         egcd_pkg::COND_NO_REQ:   jump = !req_valid;
         egcd_pkg::COND_CUR_ZERO: jump = status.cur_zero;
         egcd_pkg::COND_COUNT_NZ: jump = status.count_nz;
         egcd_pkg::COND_OUT_BUSY: jump = status.out_busy;
         default:                 jump = 1'b1;
      endcase
      step_in = jump ? ctrl.target : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= egcd_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign idle = (step_ff == egcd_pkg::STEP_IDLE);

endmodule

>>> rtl/egcd_datapath.sv
// Datapath: remainder pair, coefficient pairs, a one-bit-per-cycle restoring
// divider with shift-add quotient products, and the result register.
// Depends on egcd_pkg.
module egcd_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  egcd_pkg::ctrl_word_type                   ctrl,
   input  logic                                      req_valid,
   input  logic        [egcd_pkg::OPERAND_WIDTH-1:0] operand_a,
   input  logic        [egcd_pkg::OPERAND_WIDTH-1:0] operand_b,
   input  logic                                      rsp_ready,
   output egcd_pkg::status_type                      status,
   output logic                                      rsp_valid,
   output logic        [egcd_pkg::OPERAND_WIDTH-1:0] divisor,
   output logic signed [egcd_pkg::COEFF_WIDTH-1:0]   coeff_a,
   output logic signed [egcd_pkg::COEFF_WIDTH-1:0]   coeff_b
);

   localparam int W = egcd_pkg::OPERAND_WIDTH;
   localparam int C = egcd_pkg::COEFF_WIDTH;

   logic [W-1:0] cur_ff, cur_in, prev_ff, prev_in, rem_ff, rem_in, dvd_ff, dvd_in;
   logic [C-1:0] cx_ff, cx_in, cy_ff, cy_in, px_ff, px_in, py_ff, py_in;
   logic [C-1:0] accx_ff, accx_in, accy_ff, accy_in;
   logic [egcd_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] divisor_ff, divisor_in;
   logic [C-1:0] coeff_a_ff, coeff_a_in, coeff_b_ff, coeff_b_in;
   logic [W:0]   shifted;
   logic [W+1:0] trial;
   logic         qbit;
   logic         out_busy;

   assign out_busy = rsp_valid_ff && !rsp_ready;
   assign shifted  = {rem_ff, dvd_ff[W-1]};
   assign trial    = {1'b0, shifted} - {2'b00, cur_ff};
   assign qbit     = !trial[W+1];

   always_comb begin
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      accx_in      = accx_ff;
      accy_in      = accy_ff;
      count_in     = count_ff;
      divisor_in   = divisor_ff;
      coeff_a_in   = coeff_a_ff;
      coeff_b_in   = coeff_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (ctrl.op)
         egcd_pkg::OP_LOAD: begin
            if (req_valid) begin
               cur_in  = operand_a;
               prev_in = operand_b;
               cx_in   = C'(1);
               cy_in   = '0;
               px_in   = '0;
               py_in   = C'(1);
            end
         end
         egcd_pkg::OP_DIV_INIT: begin
            rem_in   = '0;
            dvd_in   = prev_ff;
            accx_in  = '0;
            accy_in  = '0;
            count_in = egcd_pkg::COUNT_WIDTH'(W - 1);
         end
         egcd_pkg::OP_DIV_STEP: begin
            rem_in   = qbit ? trial[W-1:0] : shifted[W-1:0];
            dvd_in   = {dvd_ff[W-2:0], 1'b0};
            accx_in  = {accx_ff[C-2:0], 1'b0} + (qbit ? cx_ff : '0);
            accy_in  = {accy_ff[C-2:0], 1'b0} + (qbit ? cy_ff : '0);
            count_in = count_ff - 1'b1;
         end
         egcd_pkg::OP_UPDATE: begin
            px_in   = cx_ff;
            py_in   = cy_ff;
            cx_in   = px_ff - accx_ff;
            cy_in   = py_ff - accy_ff;
            prev_in = cur_ff;
            cur_in  = rem_ff;
         end
         egcd_pkg::OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               divisor_in   = prev_ff;
               coeff_a_in   = px_ff;
               coeff_b_in   = py_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      accx_ff    <= accx_in;
      accy_ff    <= accy_in;
      count_ff   <= count_in;
      divisor_ff <= divisor_in;
      coeff_a_ff <= coeff_a_in;
      coeff_b_ff <= coeff_b_in;
   end

   assign status.cur_zero = (cur_ff == '0);
   assign status.count_nz = (count_ff != '0);
   assign status.out_busy = out_busy;

   assign rsp_valid = rsp_valid_ff;
   assign divisor   = divisor_ff;
   assign coeff_a   = coeff_a_ff;
   assign coeff_b   = coeff_b_ff;

endmodule

>>> rtl/extended_gcd_bezout_top.sv
// Extended gcd with Bezout coefficients: a request carries operand_a and
// operand_b; the result carries divisor = gcd(a, b) and signed coeff_a,
// coeff_b with coeff_a * a + coeff_b * b = divisor. If operand_a is zero the
// result is operand_b with coefficients 0 and 1.
// Both channels use valid/ready; a request is taken when both are high.
// One request is worked on at a time; req_chan.ready is high only while the
// sequencer waits at its idle step.
// After the request is taken, each Euclid round runs a test, a divider
// set-up, one divider step per quotient bit and an update; a final test
// then finds the current remainder zero and the emit step loads the result
// register once it is free. A request needs at most 46 Euclid rounds.
// After the result is loaded the sequencer passes the default step behind
// the emit step before it is idle again and can take a new request.
// The bit-serial divider and its shift-add coefficient products set the
// round length.
// The result register holds its result while rsp_chan.ready is low; a new
// request can be taken meanwhile, and the next result waits at its final
// step until the register is free.
// Reset is synchronous; it empties the result register and returns the
// sequencer to its idle step.
module extended_gcd_bezout_top (
   input  logic       clock,
   input  logic       reset,
   egcd_req_if.sink   req_chan,
   egcd_rsp_if.source rsp_chan
);

   egcd_pkg::ctrl_word_type ctrl;
   egcd_pkg::status_type    status;
   logic                    idle;

   egcd_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .ctrl      (ctrl),
      .idle      (idle)
   );

   egcd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_valid (req_chan.valid),
      .operand_a (req_chan.operand_a),
      .operand_b (req_chan.operand_b),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .rsp_valid (rsp_chan.valid),
      .divisor   (rsp_chan.divisor),
      .coeff_a   (rsp_chan.coeff_a),
      .coeff_b   (rsp_chan.coeff_b)
   );

   assign req_chan.ready = idle;

endmodule

>>> rtl/egcd_checker.sv
// Port-level checks for the extended gcd block, attached by a bind.
// Depends on egcd_pkg and extended_gcd_bezout_top.
module egcd_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      req_valid,
   input logic                                      req_ready,
   input logic                                      rsp_valid,
   input logic                                      rsp_ready,
   input logic        [egcd_pkg::OPERAND_WIDTH-1:0] divisor,
   input logic signed [egcd_pkg::COEFF_WIDTH-1:0]   coeff_a,
   input logic signed [egcd_pkg::COEFF_WIDTH-1:0]   coeff_b
);

   // A stalled result stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(divisor)
         && $stable(coeff_a) && $stable(coeff_b))
      else $error("stalled result changed");

   // After a request is taken the block is busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while still working");

   // A result is never produced in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A new result only appears after a busy cycle.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without work");

endmodule

bind extended_gcd_bezout_top egcd_checker u_egcd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .divisor   (rsp_chan.divisor),
   .coeff_a   (rsp_chan.coeff_a),
   .coeff_b   (rsp_chan.coeff_b)
);
